FILE: hw/rtl/ppbf_pkg.sv
`default_nettype none
package ppbf_pkg;

   localparam int VALUE_WIDTH = 40;
   // byte-padded width of the stream data words
   localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   // trial divisors never pass the square root of the value by more than a few
   localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCHECK,
      ST_DIVIDE,
      ST_DCHECK,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/prime_power_base_finder_core.sv
// Each accepted value runs trial divisions (2, then odd values up to the smallest factor or
// the root), then divide passes: none without a factor, else one more than its multiplicity.
// Throughput: one word at a time; the bit-serial restoring divider, one quotient bit per
// cycle, sets the pace. Worst case is a 40-bit prime, about 2^19 trials.
// Reset (synchronous, active high) returns to idle and drops any pending result.
`default_nettype none
module prime_power_base_finder_core import ppbf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [TDATA_WIDTH-1:0] req_tdata,   // [VALUE_WIDTH-1:0] value
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TDATA_WIDTH-1:0]      rsp_tdata    // [VALUE_WIDTH-1:0] answer
);

   state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] wq_ff, wq_in;       // dividend shifting out, quotient shifting in
   logic [VALUE_WIDTH-1:0] work_ff, work_in;
   logic [VALUE_WIDTH-1:0] ans_ff, ans_in;
   logic [VALUE_WIDTH-1:0] rsp_answer_ff, rsp_answer_in;
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]   div_ff, div_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [DIV_WIDTH:0]     shift_val;
   logic [DIV_WIDTH+1:0]   diff;
   logic                   qbit;
   logic [DIV_WIDTH-1:0]   rem_step;
   logic [VALUE_WIDTH-1:0] wq_step;
   logic                   last_bit;
   logic                   div_gt_q;
   logic [DIV_WIDTH-1:0]   div_next;
   logic                   req_fire;
   logic                   slot_free;

   // one restoring division step per cycle
   assign shift_val = {rem_ff, wq_ff[VALUE_WIDTH-1]};
   assign diff      = {1'b0, shift_val} - {2'b00, div_ff};
   assign qbit      = ~diff[DIV_WIDTH+1];
   assign rem_step  = qbit ? diff[DIV_WIDTH-1:0] : shift_val[DIV_WIDTH-1:0];
   assign wq_step   = {wq_ff[VALUE_WIDTH-2:0], qbit};
   assign last_bit  = (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1));

   assign div_gt_q  = (VALUE_WIDTH'(div_ff) > wq_ff);
   assign div_next  = (div_ff == DIV_WIDTH'(2)) ? DIV_WIDTH'(3) : div_ff + DIV_WIDTH'(2);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(rsp_answer_ff);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      wq_in         = wq_ff;
      work_in       = work_ff;
      ans_in        = ans_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      cnt_in        = cnt_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in     = req_tdata[VALUE_WIDTH-1:0];
               wq_in    = req_tdata[VALUE_WIDTH-1:0];
               rem_in   = '0;
               cnt_in   = '0;
               div_in   = DIV_WIDTH'(2);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH, ST_DIVIDE: begin
            wq_in  = wq_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CNT_WIDTH'(1);
            if (last_bit) begin
               state_in = (state_ff == ST_SEARCH) ? ST_SCHECK : ST_DCHECK;
            end
         end
         ST_SCHECK: begin
            rem_in = '0;
            cnt_in = '0;
            priority if (div_gt_q) begin
               // no factor up to the square root: value is 0, 1 or prime
               ans_in   = n_ff;
               state_in = ST_EMIT;
            end else if (rem_ff == '0) begin
               work_in  = n_ff;
               wq_in    = n_ff;
               state_in = ST_DIVIDE;
            end else begin
               div_in   = div_next;
               wq_in    = n_ff;
               state_in = ST_SEARCH;
            end
         end
         ST_DCHECK: begin
            rem_in = '0;
            cnt_in = '0;
            if (rem_ff == '0) begin
               // divides again: keep the quotient and go on
               work_in  = wq_ff;
               state_in = ST_DIVIDE;
            end else begin
               ans_in   = (work_ff == VALUE_WIDTH'(1)) ? VALUE_WIDTH'(div_ff)
                                                       : VALUE_WIDTH'(1);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ans_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      wq_ff         <= wq_in;
      work_ff       <= work_in;
      ans_ff        <= ans_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      cnt_ff        <= cnt_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   a_start_search: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SEARCH && div_ff == DIV_WIDTH'(2)))
      else $error("accepted word did not start the search at divisor two");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_DIVIDE) |-> (rem_ff < div_ff))
      else $error("partial remainder reached the divisor");

   a_factor_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_ff >= DIV_WIDTH'(2) && work_ff != '0))
      else $error("dividing with a bad factor or a zero working value");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free) |=> (rsp_valid_ff && rsp_answer_ff == $past(ans_ff)))
      else $error("result not moved to the output register");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ppbf_pkg::*;

   localparam longint unsigned VALUE_MAX   = (64'd1 << VALUE_WIDTH) - 64'd1;
   localparam int              RANDOM_RUNS = 100;
   localparam int              QUIET_LIMIT = 100000;
   localparam int              PROBE_COUNT = 23;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [VALUE_WIDTH-1:0] answer;
      logic                   known;
   } probe_type;

   // answer column is only trusted where known is set; other rows go to the predictor
   probe_type probes [PROBE_COUNT] = '{
      '{40'd0,                 40'd0,      1'b1},
      '{40'd1,                 40'd1,      1'b1},
      '{40'd2,                 40'd2,      1'b1},
      '{40'd3,                 40'd3,      1'b1},
      '{40'd4,                 40'd2,      1'b1},
      '{40'd6,                 40'd1,      1'b1},
      '{40'd12,                40'd1,      1'b1},
      '{40'd25,                40'd5,      1'b1},
      '{40'd49,                40'd7,      1'b1},
      '{40'd97,                40'd97,     1'b1},
      '{40'd1024,              40'd2,      1'b1},
      '{40'd65521,             40'd65521,  1'b1},
      '{40'h01_0000_0000,      40'd2,      1'b1},
      '{40'h80_0000_0000,      40'd2,      1'b1},
      '{40'hFF_FFFF_FFFF,      40'd1,      1'b1},
      '{40'hFF_FFFF_FFFE,      40'd1,      1'b1},
      '{40'd847288609443,      40'd3,      1'b1},
      '{40'd678223072849,      40'd7,      1'b1},
      '{40'd1018081,           40'd1009,   1'b1},
      '{40'd1000003,           40'd0,      1'b0},
      '{40'h80_0000_0001,      40'd0,      1'b0},
      '{40'h55_5555_5555,      40'd0,      1'b0},
      '{40'hAA_AAAA_AAAA,      40'd0,      1'b0}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_WIDTH-1:0] rsp_tdata;

   logic [VALUE_WIDTH-1:0] answers_due [$];
   int                     values_sent     = 0;
   int                     answers_checked = 0;
   int                     answers_above_1 = 0;
   int                     bad_answers     = 0;
   int                     quiet_cycles    = 0;

   prime_power_base_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // smallest d >= 2 with d*d <= n that divides n, or 0 when there is none
   function automatic longint unsigned least_factor(input longint unsigned n);
      longint unsigned d;
      d = 64'd2;
      while (d <= n / d) begin
         if (n % d == 64'd0) return d;
         d = (d == 64'd2) ? 64'd3 : d + 64'd2;
      end
      return 64'd0;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] prime_base(input logic [VALUE_WIDTH-1:0] value);
      longint unsigned n, p, rest;
      n = 64'(value);
      p = least_factor(n);
      if (p == 64'd0) return value;
      rest = n;
      while (rest % p == 64'd0) rest = rest / p;
      return (rest == 64'd1) ? VALUE_WIDTH'(p) : VALUE_WIDTH'(1);
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   // mostly prime powers and values with a small factor, so trial division stays short
   function automatic logic [VALUE_WIDTH-1:0] random_value();
      longint unsigned wide, p, v, m;
      int unsigned     kind, count;
      kind  = $urandom_range(0, 99);
      wide  = {$urandom, $urandom} & VALUE_MAX;
      m     = 64'($urandom_range(2, 600));
      p     = least_factor(m);
      if (p == 64'd0) p = m;
      v     = p;
      count = $urandom_range(1, 40);
      repeat (count - 1) if (v * p <= VALUE_MAX) v = v * p;
      m     = 64'($urandom_range(2, 600));
      if (kind < 25) return VALUE_WIDTH'($urandom_range(0, 65535));
      if (kind < 50) return VALUE_WIDTH'(v);
      if (kind < 65) return VALUE_WIDTH'(wide & ~64'd1);
      if (kind < 80) return VALUE_WIDTH'((wide / 3) * 3);
      return (v * m <= VALUE_MAX) ? VALUE_WIDTH'(v * m) : VALUE_WIDTH'(p * m);
   endfunction

   task automatic offer_value(input logic [VALUE_WIDTH-1:0] value,
                              input logic [VALUE_WIDTH-1:0] answer, input bit eager);
      int gap;
      gap = eager ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_WIDTH'(value);
      do @(posedge clock); while (!req_tready);
      answers_due = {answers_due, answer};
      values_sent++;
   endtask

   task automatic drain_answers();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [VALUE_WIDTH-1:0] value;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (probes[i]) begin
         offer_value(probes[i].value,
                     probes[i].known ? probes[i].answer : prime_base(probes[i].value), 1'b0);
      end
      drain_answers();
      for (int i = 0; i < RANDOM_RUNS; i++) begin
         if (i == 50) drain_answers();
         value = random_value();
         offer_value(value, prime_base(value), i >= 70 && i < 85);
      end
      drain_answers();
      repeat (50) @(posedge clock);
      $display("testbench: %0d values examined, %0d answers checked, %0d of them above one",
               values_sent, answers_checked, answers_above_1);
      if (bad_answers == 0 && answers_due.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off, and a stretch with ready held high
   initial begin
      int hold;
      bit stalled;
      hold    = 0;
      stalled = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!stalled && answers_checked >= 35) begin
            stalled = 1'b1;
            hold    = 25000;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else if (answers_checked >= 70 && answers_checked < 85) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            hold = pick_gap();
            rsp_tready <= (hold == 0);
            if (hold > 0) hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      logic [VALUE_WIDTH-1:0] due;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               bad_answers++;
               $display("%0t: answer %0d with none expected", $time, rsp_tdata);
            end else begin
               due = answers_due.pop_front();
               answers_checked++;
               if (due > 1) answers_above_1++;
               if (rsp_tdata !== TDATA_WIDTH'(due)) begin
                  bad_answers++;
                  $display("%0t: answer mismatch, expected %0d, actual %0d",
                           $time, due, rsp_tdata);
               end
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

endmodule
